[src/comam_pkg.sv]
// Shared types and constants for the center-of-mass / angular-momentum block.
`timescale 1ns / 1ps
`default_nettype none
package comam_pkg;

  localparam int unsigned MSUM_W = 40;
  localparam logic [MSUM_W-1:0] MSUM_MAX = {MSUM_W{1'b1}};

  typedef enum logic [1:0] {
    ERR_OK       = 2'd0,
    ERR_ZERO_MASS = 2'd1,
    ERR_OVERFLOW = 2'd2
  } err_t;

  // Datapath commands issued by the controller.
  typedef struct packed {
    logic load;        // store and accumulate the input word
    logic div_start;   // launch the six center-of-mass divisions
    logic pass_start;  // zero angular momentum, reset read index
    logic pass_rd;     // issue a store read at the pass index
    logic pass_acc;    // one pipeline step of the second pass
    logic out_load;    // capture the result word
    logic clear;       // drop the per-set sums
  } cmd_t;

  // Status returned to the controller.
  typedef struct packed {
    logic div_busy;
    logic pass_last;   // the read just issued is the final particle
    logic full;        // particle store already holds MAX_PARTICLES
    logic overflow;
    logic zero_mass;
  } stat_t;

  function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      sat_add64 = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      sat_add64 = s[63:0];
    end
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
    if (v[32] != v[31]) begin
      sat32 = v[32] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
    end else begin
      sat32 = v[31:0];
    end
  endfunction

endpackage
`default_nettype wire

[src/comam_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module comam_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

[src/comam_div.sv]
// Restoring divider: |dividend| / divisor, one quotient bit a cycle, 32-bit saturated.
`timescale 1ns / 1ps
`default_nettype none
module comam_div (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  input  wire logic signed [63:0]      dividend,
  input  wire logic [comam_pkg::MSUM_W-1:0] divisor,
  output logic                         busy,
  output logic signed [31:0]           quot
);
  localparam int unsigned MW = comam_pkg::MSUM_W;

  logic [63:0]   mag;      // shifts out dividend bits, shifts in quotient bits
  logic [MW:0]   rem;
  logic [MW-1:0] dvs;
  logic          neg;
  logic [6:0]    cnt;
  logic [MW:0]   trial;
  logic          ge;

  always_comb begin
    trial = {rem[MW-1:0], mag[63]};
    ge    = trial >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 7'd64;
    end else if (busy) begin
      cnt <= cnt - 7'd1;
      if (cnt == 7'd1) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[63];
      mag <= dividend[63] ? (64'd0 - dividend) : dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      rem <= ge ? (trial - {1'b0, dvs}) : trial;
      mag <= {mag[62:0], ge};
    end
  end

  // mag holds the quotient once done
  always_comb begin
    if (neg) begin
      quot = (mag >= 64'h8000_0000) ? {1'b1, 31'd0} : 32'(64'd0 - mag);
    end else begin
      quot = (mag > 64'h7FFF_FFFF) ? {1'b0, {31{1'b1}}} : mag[31:0];
    end
  end
endmodule
`default_nettype wire

[src/comam_datapath.sv]
// Datapath: particle stores, weighted sums, dividers and the angular-momentum pass.
`timescale 1ns / 1ps
`default_nettype none
module comam_datapath #(
  parameter int unsigned MAX_PARTICLES = 256
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire comam_pkg::cmd_t     cmd,
  output comam_pkg::stat_t         stat,
  input  wire logic signed [31:0]  pos_x,
  input  wire logic signed [31:0]  pos_y,
  input  wire logic signed [31:0]  pos_z,
  input  wire logic signed [31:0]  vel_x,
  input  wire logic signed [31:0]  vel_y,
  input  wire logic signed [31:0]  vel_z,
  input  wire logic [31:0]         mass,
  output logic signed [31:0]       cm_pos_x,
  output logic signed [31:0]       cm_pos_y,
  output logic signed [31:0]       cm_pos_z,
  output logic signed [31:0]       cm_vel_x,
  output logic signed [31:0]       cm_vel_y,
  output logic signed [31:0]       cm_vel_z,
  output logic signed [63:0]       ang_mom_x,
  output logic signed [63:0]       ang_mom_y,
  output logic signed [63:0]       ang_mom_z,
  output logic [39:0]              total_mass,
  output logic [1:0]               error_code
);
  localparam int unsigned AW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
  localparam int unsigned CW = $clog2(MAX_PARTICLES + 1);
  localparam int unsigned MW = comam_pkg::MSUM_W;
  localparam int unsigned RD = (MAX_PARTICLES > 1) ? MAX_PARTICLES : 2;

  logic [CW-1:0]            count;
  logic [MW-1:0]            msum;
  logic                     ovf;
  logic signed [63:0]       wsum [6];
  logic signed [31:0]       din  [6];
  logic signed [63:0]       wprod [6];
  logic [CW-1:0]            ridx;
  logic [31:0]              rdat [7];
  logic [31:0]              cm   [6];
  logic                     div_busy [6];
  logic signed [63:0]       amom [3];

  assign din[0] = pos_x;
  assign din[1] = pos_y;
  assign din[2] = pos_z;
  assign din[3] = vel_x;
  assign din[4] = vel_y;
  assign din[5] = vel_z;

  // Exact Q32.32 products of each coordinate with the mass.
  always_comb begin
    for (int k = 0; k < 6; k++) begin
      wprod[k] = din[k] * $signed({1'b0, mass});
    end
  end

  // Store writes and weighted sums.
  logic [MW:0] msum_add;
  assign msum_add = {1'b0, msum} + {{(MW-31){1'b0}}, mass};

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      count <= '0;
      msum  <= '0;
      ovf   <= 1'b0;
      for (int k = 0; k < 6; k++) begin
        wsum[k] <= '0;
      end
    end else if (cmd.load) begin
      if (stat.full) begin
        ovf <= 1'b1;
      end else begin
        count <= count + CW'(1);
        msum  <= msum_add[MW] ? comam_pkg::MSUM_MAX : msum_add[MW-1:0];
        for (int k = 0; k < 6; k++) begin
          wsum[k] <= comam_pkg::sat_add64(wsum[k], wprod[k]);
        end
      end
    end
  end

  assign stat.full      = count >= CW'(MAX_PARTICLES);
  assign stat.overflow  = ovf;
  assign stat.zero_mass = msum == '0;

  for (genvar g = 0; g < 7; g++) begin : g_store
    comam_ram #(.WIDTH(32), .DEPTH(RD)) u_ram (
      .clk   (clk),
      .we    (cmd.load && !stat.full),
      .waddr (count[AW-1:0]),
      .wdata ((g == 6) ? mass : din[(g == 6) ? 0 : g]),
      .re    (cmd.pass_rd),
      .raddr (ridx[AW-1:0]),
      .rdata (rdat[g])
    );
  end

  for (genvar g = 0; g < 6; g++) begin : g_div
    comam_div u_div (
      .clk      (clk),
      .rst      (rst),
      .start    (cmd.div_start),
      .dividend (wsum[g]),
      .divisor  (msum),
      .busy     (div_busy[g]),
      .quot     (cm[g])
    );
  end
  assign stat.div_busy = div_busy[0];

  // Pass read index.
  always_ff @(posedge clk) begin
    if (rst || cmd.pass_start) begin
      ridx <= '0;
    end else if (cmd.pass_rd) begin
      ridx <= ridx + CW'(1);
    end
  end
  assign stat.pass_last = ridx == count - CW'(1);

  // Pass pipeline, stepped by pass_acc:
  // s1 relative values, s2 products, s3 cross, s4 mass products, s5 accumulate.
  logic signed [31:0] rel [6];
  logic [31:0]        m1, m2, m3;
  logic signed [63:0] prd [6];
  logic signed [64:0] crs [3];
  logic [64:0]        cmag [3];
  logic               cneg [3];
  logic [63:0]        plo [3];
  logic [63:0]        phi [3];
  logic               pneg [3];
  logic [32:0]        chi;
  logic [64:0]        r65;
  logic signed [63:0] term [3];

  always_ff @(posedge clk) begin
    if (cmd.pass_acc) begin
      for (int k = 0; k < 6; k++) begin
        rel[k] <= comam_pkg::sat32(33'($signed(rdat[k])) - 33'($signed(cm[k])));
      end
      m1 <= rdat[6];
      prd[0] <= rel[1] * rel[5];
      prd[1] <= rel[2] * rel[4];
      prd[2] <= rel[2] * rel[3];
      prd[3] <= rel[0] * rel[5];
      prd[4] <= rel[0] * rel[4];
      prd[5] <= rel[1] * rel[3];
      m2 <= m1;
      for (int k = 0; k < 3; k++) begin
        crs[k] <= 65'(prd[2*k]) - 65'(prd[2*k+1]);
      end
      m3 <= m2;
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      cneg[k] = crs[k][64];
      cmag[k] = cneg[k] ? (65'd0 - crs[k]) : crs[k];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pass_acc) begin
      for (int k = 0; k < 3; k++) begin
        plo[k]  <= 64'(cmag[k][31:0]) * 64'(m3);
        phi[k]  <= 64'(cmag[k][64:32]) * 64'(m3);
        pneg[k] <= cneg[k];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      chi = 33'(phi[k] >> 47);
      r65 = {1'b0, phi[k][47:0], 16'd0} + 65'(plo[k] >> 16);
      if (chi != '0 || r65[64]) begin
        term[k] = pneg[k] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      end else if (pneg[k]) begin
        term[k] = (r65[63]) ? {1'b1, 63'd0} : 64'(65'd0 - r65);
      end else begin
        term[k] = r65[63] ? {1'b0, {63{1'b1}}} : r65[63:0];
      end
    end
  end

  // Accumulate only when a valid particle sits in the last stage.
  logic [4:0] vpipe;
  always_ff @(posedge clk) begin
    if (rst || cmd.pass_start) begin
      vpipe <= '0;
      for (int k = 0; k < 3; k++) begin
        amom[k] <= '0;
      end
    end else if (cmd.pass_acc) begin
      vpipe <= {vpipe[3:0], cmd.pass_rd};
      if (vpipe[4]) begin
        for (int k = 0; k < 3; k++) begin
          amom[k] <= comam_pkg::sat_add64(amom[k], term[k]);
        end
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (ovf || msum == '0) begin
        {cm_pos_x, cm_pos_y, cm_pos_z, cm_vel_x, cm_vel_y, cm_vel_z} <= '0;
        {ang_mom_x, ang_mom_y, ang_mom_z} <= '0;
        total_mass <= '0;
        error_code <= ovf ? comam_pkg::ERR_OVERFLOW : comam_pkg::ERR_ZERO_MASS;
      end else begin
        cm_pos_x   <= cm[0];
        cm_pos_y   <= cm[1];
        cm_pos_z   <= cm[2];
        cm_vel_x   <= cm[3];
        cm_vel_y   <= cm[4];
        cm_vel_z   <= cm[5];
        ang_mom_x  <= amom[0];
        ang_mom_y  <= amom[1];
        ang_mom_z  <= amom[2];
        total_mass <= msum;
        error_code <= comam_pkg::ERR_OK;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= CW'(MAX_PARTICLES))
    else $error("particle count beyond capacity");
  assert property (@(posedge clk) disable iff (rst) cmd.pass_rd |-> count != '0)
    else $error("store read with empty set");
  assert property (@(posedge clk) disable iff (rst) cmd.div_start |-> !stat.zero_mass)
    else $error("divide launched with zero mass");
endmodule
`default_nettype wire

[src/comam_ctrl.sv]
// Controller: load, divide, second pass and result handoff sequencing.
`timescale 1ns / 1ps
`default_nettype none
module comam_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic             last_particle,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output comam_pkg::cmd_t       cmd,
  input  wire comam_pkg::stat_t stat
);
  typedef enum logic [2:0] {
    S_LOAD, S_DIV0, S_DIV, S_PASS, S_DRAIN, S_OUT, S_HOLD
  } state_t;

  state_t     state;
  logic       reading;
  logic [2:0] drain;

  wire in_acc = in_valid && in_ready;

  always_comb begin
    cmd = '0;
    in_ready = (state == S_LOAD);
    cmd.load = in_acc;
    unique case (state)
      S_LOAD: ;
      S_DIV0: begin
        cmd.div_start  = !stat.zero_mass;
        cmd.pass_start = 1'b1;
      end
      S_DIV: ;
      S_PASS: begin
        cmd.pass_rd  = reading;
        cmd.pass_acc = 1'b1;
      end
      S_DRAIN: cmd.pass_acc = 1'b1;
      S_OUT: begin
        cmd.out_load = 1'b1;
        cmd.clear    = 1'b1;
      end
      S_HOLD: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      out_valid <= 1'b0;
      reading   <= 1'b0;
      drain     <= '0;
    end else begin
      unique case (state)
        S_LOAD: begin
          if (in_acc && last_particle) begin
            // overflow skips straight to the result
            if (stat.overflow || stat.full) begin
              state <= S_OUT;
            end else begin
              state <= S_DIV0;
            end
          end
        end
        S_DIV0: state <= stat.zero_mass ? S_OUT : S_DIV;
        S_DIV: begin
          if (!stat.div_busy) begin
            state   <= S_PASS;
            reading <= 1'b1;
          end
        end
        S_PASS: begin
          if (stat.pass_last) begin
            state <= S_DRAIN;
            drain <= 3'd5;
          end
        end
        S_DRAIN: begin
          drain <= drain - 3'd1;
          if (drain == 3'd1) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          state     <= S_HOLD;
          out_valid <= 1'b1;
        end
        S_HOLD: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state     <= S_LOAD;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) out_valid |-> !in_ready)
    else $error("input taken while result pending");
  assert property (@(posedge clk) disable iff (rst) cmd.out_load |=> out_valid)
    else $error("result not presented");
  assert property (@(posedge clk) disable iff (rst) cmd.pass_rd |-> state == S_PASS)
    else $error("store read outside pass");
endmodule
`default_nettype wire

[src/center_of_mass_angular_momentum.sv]
// Top level of the center-of-mass and angular-momentum block.
// Usage:
//   Input channel (in_valid/in_ready) takes one particle word per cycle:
//   position, velocity (signed Q16.16), mass (unsigned Q16.16), last_particle.
//   Each word is written into seven particle RAMs and folded into the
//   mass sum and the six mass-weighted sums in the cycle it is accepted.
//   Words beyond MAX_PARTICLES are dropped and flag error 2.
//   After the word marked last, in_ready drops while the block finishes:
//   a setup state, the divide (64 quotient bits, six dividers in parallel,
//   then a check that they have finished), then a pass over N stored
//   particles at one per cycle plus a drain of the pass pipeline, then
//   a state that loads the result register. The rate is one particle
//   per cycle while loading. Overflow skips the divide and pass and goes
//   straight to the result register after the last word; zero total mass
//   goes there from the setup state.
//   The result word stays on the output channel (out_valid/out_ready)
//   until taken; a stalled receiver holds the block with in_ready low.
//   Reset clears the counts, sums and handshakes; RAM contents stay as
//   they are and are only read where written in the current set.
`timescale 1ns / 1ps
`default_nettype none
module center_of_mass_angular_momentum #(
  parameter int unsigned MAX_PARTICLES = 256
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [31:0] pos_x,
  input  wire logic signed [31:0] pos_y,
  input  wire logic signed [31:0] pos_z,
  input  wire logic signed [31:0] vel_x,
  input  wire logic signed [31:0] vel_y,
  input  wire logic signed [31:0] vel_z,
  input  wire logic [31:0]        mass,
  input  wire logic               last_particle,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      cm_pos_x,
  output logic signed [31:0]      cm_pos_y,
  output logic signed [31:0]      cm_pos_z,
  output logic signed [31:0]      cm_vel_x,
  output logic signed [31:0]      cm_vel_y,
  output logic signed [31:0]      cm_vel_z,
  output logic signed [63:0]      ang_mom_x,
  output logic signed [63:0]      ang_mom_y,
  output logic signed [63:0]      ang_mom_z,
  output logic [39:0]             total_mass,
  output logic [1:0]              error_code
);
  comam_pkg::cmd_t  cmd;
  comam_pkg::stat_t stat;

  // Sequencing: load, divide, pass, hand off.
  comam_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .last_particle (last_particle),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .cmd           (cmd),
    .stat          (stat)
  );

  // Storage and arithmetic.
  comam_datapath #(.MAX_PARTICLES(MAX_PARTICLES)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .pos_z      (pos_z),
    .vel_x      (vel_x),
    .vel_y      (vel_y),
    .vel_z      (vel_z),
    .mass       (mass),
    .cm_pos_x   (cm_pos_x),
    .cm_pos_y   (cm_pos_y),
    .cm_pos_z   (cm_pos_z),
    .cm_vel_x   (cm_vel_x),
    .cm_vel_y   (cm_vel_y),
    .cm_vel_z   (cm_vel_z),
    .ang_mom_x  (ang_mom_x),
    .ang_mom_y  (ang_mom_y),
    .ang_mom_z  (ang_mom_z),
    .total_mass (total_mass),
    .error_code (error_code)
  );
endmodule
`default_nettype wire

[sim/tb.sv]
// Testbench for the center-of-mass and angular-momentum block.
`timescale 1ns / 1ps
`default_nettype none
module tb;

  localparam int NPART = 256;
  localparam longint CYCLE_LIMIT = 2000000;
  localparam longint S64_MAX = 64'sh7FFFFFFFFFFFFFFF;
  localparam longint S64_MIN = 64'sh8000000000000000;

  typedef struct {
    logic signed [31:0] px, py, pz, vx, vy, vz;
    logic [31:0] m;
    logic lst;
  } particle_t;

  typedef struct {
    logic signed [31:0] cpx, cpy, cpz, cvx, cvy, cvz;
    logic signed [63:0] lx, ly, lz;
    logic [39:0] tm;
    logic [1:0] err;
  } summary_t;

  // Directed row: particle plus optional typed-in expectation
  typedef struct {
    particle_t p;
    bit fixed;
    summary_t want;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic signed [31:0] vel_x = '0, vel_y = '0, vel_z = '0;
  logic [31:0] mass = '0;
  logic last_particle = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] cm_pos_x, cm_pos_y, cm_pos_z, cm_vel_x, cm_vel_y, cm_vel_z;
  logic signed [63:0] ang_mom_x, ang_mom_y, ang_mom_z;
  logic [39:0] total_mass;
  logic [1:0] error_code;

  always #2 clk = ~clk;

  center_of_mass_angular_momentum DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .vel_x(vel_x), .vel_y(vel_y), .vel_z(vel_z),
    .mass(mass), .last_particle(last_particle),
    .out_valid(out_valid), .out_ready(out_ready),
    .cm_pos_x(cm_pos_x), .cm_pos_y(cm_pos_y), .cm_pos_z(cm_pos_z),
    .cm_vel_x(cm_vel_x), .cm_vel_y(cm_vel_y), .cm_vel_z(cm_vel_z),
    .ang_mom_x(ang_mom_x), .ang_mom_y(ang_mom_y), .ang_mom_z(ang_mom_z),
    .total_mass(total_mass), .error_code(error_code)
  );

  // Shadow copy of the particle set
  particle_t set_mem[NPART];
  int set_cnt;
  logic [39:0] msum;
  logic signed [63:0] wpos[3], wvel[3];
  bit set_over;

  summary_t pending_sums[$];
  int errors;
  bit in_calm, out_calm;
  longint cyc;

  function automatic logic signed [63:0] add_sat(logic signed [63:0] a, logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s > 65'sd0 + S64_MAX) return S64_MAX;
    if (s < 65'sd0 + S64_MIN) return S64_MIN;
    return s[63:0];
  endfunction

  function automatic logic signed [31:0] clip32(logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Weighted sum over mass, truncated toward zero
  function automatic logic signed [31:0] mean_of(logic signed [63:0] s, logic [39:0] ms);
    logic [63:0] mag, q;
    mag = s[63] ? -s : s;
    q = mag / {24'd0, ms};
    if (s[63]) return (q >= 64'h80000000) ? 32'sh80000000 : -q[31:0];
    return (q > 64'h7FFFFFFF) ? 32'sh7FFFFFFF : q[31:0];
  endfunction

  // (c * m) >> 16 toward zero, saturated
  function automatic logic signed [63:0] torque_term(logic signed [63:0] c, logic [31:0] m);
    logic [63:0] u;
    logic [127:0] p;
    u = c[63] ? -c : c;
    p = ({64'd0, u} * {96'd0, m}) >> 16;
    if (p[127:63] != 0) return c[63] ? S64_MIN : S64_MAX;
    return c[63] ? -p[63:0] : p[63:0];
  endfunction

  function automatic summary_t finish_set();
    summary_t r;
    logic signed [31:0] cp[3], cv[3], rp[3], rv[3];
    logic signed [63:0] lm[3], c[3];
    r = '{default: '0};
    r.err = comam_pkg::ERR_OK;
    if (set_over) r.err = comam_pkg::ERR_OVERFLOW;
    else if (msum == 0) r.err = comam_pkg::ERR_ZERO_MASS;
    else begin
      for (int k = 0; k < 3; k++) begin
        cp[k] = mean_of(wpos[k], msum);
        cv[k] = mean_of(wvel[k], msum);
        lm[k] = '0;
      end
      for (int i = 0; i < set_cnt; i++) begin
        rp[0] = clip32(64'(set_mem[i].px) - cp[0]);
        rp[1] = clip32(64'(set_mem[i].py) - cp[1]);
        rp[2] = clip32(64'(set_mem[i].pz) - cp[2]);
        rv[0] = clip32(64'(set_mem[i].vx) - cv[0]);
        rv[1] = clip32(64'(set_mem[i].vy) - cv[1]);
        rv[2] = clip32(64'(set_mem[i].vz) - cv[2]);
        c[0] = 64'(rp[1]) * 64'(rv[2]) - 64'(rp[2]) * 64'(rv[1]);
        c[1] = 64'(rp[2]) * 64'(rv[0]) - 64'(rp[0]) * 64'(rv[2]);
        c[2] = 64'(rp[0]) * 64'(rv[1]) - 64'(rp[1]) * 64'(rv[0]);
        for (int k = 0; k < 3; k++) lm[k] = add_sat(lm[k], torque_term(c[k], set_mem[i].m));
      end
      r.cpx = cp[0]; r.cpy = cp[1]; r.cpz = cp[2];
      r.cvx = cv[0]; r.cvy = cv[1]; r.cvz = cv[2];
      r.lx = lm[0]; r.ly = lm[1]; r.lz = lm[2];
      r.tm = msum;
    end
    set_cnt = 0; msum = '0; set_over = 0;
    for (int k = 0; k < 3; k++) begin wpos[k] = '0; wvel[k] = '0; end
    return r;
  endfunction

  // Fold one particle into the shadow set; returns 1 when a result follows
  function automatic bit absorb_particle(particle_t p, output summary_t r);
    logic signed [31:0] pv[3], vv[3];
    logic [40:0] ms;
    pv = '{p.px, p.py, p.pz};
    vv = '{p.vx, p.vy, p.vz};
    if (set_cnt >= NPART) set_over = 1;
    else begin
      set_mem[set_cnt] = p;
      set_cnt++;
      ms = {1'b0, msum} + p.m;
      msum = ms[40] ? comam_pkg::MSUM_MAX : ms[39:0];
      for (int k = 0; k < 3; k++) begin
        wpos[k] = add_sat(wpos[k], 64'(pv[k]) * $signed({32'd0, p.m}));
        wvel[k] = add_sat(wvel[k], 64'(vv[k]) * $signed({32'd0, p.m}));
      end
    end
    if (p.lst) r = finish_set();
    return p.lst;
  endfunction

  function automatic logic [31:0] pick32();
    case ($urandom_range(0, 9))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return 32'hFFFFFFFF;
      3: return '0;
      4, 5: return $urandom_range(0, 32'h000FFFFF) - 32'h00080000;
      default: return $urandom;
    endcase
  endfunction

  function automatic particle_t rand_particle(bit lst);
    particle_t p;
    p.px = pick32(); p.py = pick32(); p.pz = pick32();
    p.vx = pick32(); p.vy = pick32(); p.vz = pick32();
    case ($urandom_range(0, 7))
      0: p.m = '0;
      1: p.m = 32'hFFFFFFFF;
      2, 3: p.m = $urandom;
      default: p.m = $urandom_range(1, 32'h0004FFFF);
    endcase
    p.lst = lst;
    return p;
  endfunction

  // Hold the word until accepted, idling in bursts beforehand
  task automatic send_word(particle_t p);
    summary_t r;
    if (!in_calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    pos_x <= p.px; pos_y <= p.py; pos_z <= p.pz;
    vel_x <= p.vx; vel_y <= p.vy; vel_z <= p.vz;
    mass <= p.m; last_particle <= p.lst;
    do @(posedge clk); while (!in_ready);
    if (absorb_particle(p, r)) pending_sums.push_back(r);
  endtask

  task automatic report(string what, logic [63:0] want, logic [63:0] got);
    errors++;
    if (errors <= 10) $display("mismatch %s: expected %h got %h", what, want, got);
  endtask

  // Check each result word against the oldest expectation
  always @(posedge clk) begin
    summary_t w;
    if (!rst && out_valid && out_ready) begin
      if (pending_sums.size() == 0) report("unexpected word", 0, 1);
      else begin
        w = pending_sums.pop_front();
        if (cm_pos_x !== w.cpx) report("cm_pos_x", w.cpx, cm_pos_x);
        if (cm_pos_y !== w.cpy) report("cm_pos_y", w.cpy, cm_pos_y);
        if (cm_pos_z !== w.cpz) report("cm_pos_z", w.cpz, cm_pos_z);
        if (cm_vel_x !== w.cvx) report("cm_vel_x", w.cvx, cm_vel_x);
        if (cm_vel_y !== w.cvy) report("cm_vel_y", w.cvy, cm_vel_y);
        if (cm_vel_z !== w.cvz) report("cm_vel_z", w.cvz, cm_vel_z);
        if (ang_mom_x !== w.lx) report("ang_mom_x", w.lx, ang_mom_x);
        if (ang_mom_y !== w.ly) report("ang_mom_y", w.ly, ang_mom_y);
        if (ang_mom_z !== w.lz) report("ang_mom_z", w.lz, ang_mom_z);
        if (total_mass !== w.tm) report("total_mass", w.tm, total_mass);
        if (error_code !== w.err) report("error_code", w.err, error_code);
      end
    end
  end

  // Receiver: stall in random bursts, except in the calm tail
  initial begin
    forever begin
      @(posedge clk);
      if (!out_calm && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > CYCLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  row_t rows[$];

  function automatic row_t mk(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                              logic [31:0] vx, logic [31:0] vy, logic [31:0] vz,
                              logic [31:0] m, bit lst);
    row_t r;
    r.p = '{px, py, pz, vx, vy, vz, m, lst};
    r.fixed = 0;
    r.want = '{default: '0};
    return r;
  endfunction

  initial begin
    row_t r;
    int sz, sent;
    errors = 0; cyc = 0; in_calm = 0; out_calm = 0;
    set_cnt = 0; msum = '0; set_over = 0;
    for (int k = 0; k < 3; k++) begin wpos[k] = '0; wvel[k] = '0; end

    // Zero-mass single particle: error 1, all else zero
    r = mk(32'h7FFFFFFF, 32'h80000000, 0, 32'hFFFFFFFF, 1, 0, 0, 1);
    r.fixed = 1; r.want.err = comam_pkg::ERR_ZERO_MASS; rows.push_back(r);
    // Single unit mass at the origin: no spin, cm zero
    r = mk(0, 0, 0, 0, 0, 0, 32'h00010000, 1);
    r.fixed = 1; r.want.tm = 40'h10000; r.want.err = comam_pkg::ERR_OK; rows.push_back(r);
    // Extreme positions and velocities, checked by the predictor
    rows.push_back(mk(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                      32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, 0));
    rows.push_back(mk(32'h80000000, 32'h7FFFFFFF, 32'h80000000,
                      32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF, 1));
    // Two-body orbit-like set
    rows.push_back(mk(32'h00010000, 0, 0, 0, 32'h00010000, 0, 32'h00020000, 0));
    rows.push_back(mk(32'hFFFF0000, 0, 0, 0, 32'hFFFF0000, 0, 32'h00020000, 0));
    rows.push_back(mk(0, 32'h00030000, 32'hFFFD0000, 32'h00008000, 0, 0, 0, 1));
    // Many heavy masses: weighted velocity sums saturate
    for (int i = 0; i < 4; i++)
      rows.push_back(mk(32'h12345678, 32'hEDCBA987, 32'h00000001,
                        32'h7FFFFFFF, 32'h0, 32'h80000000, 32'hFFFFFFFF, i == 3));
    // Zero mass across two particles
    rows.push_back(mk(5, 6, 7, 8, 9, 10, 0, 0));
    r = mk(32'hFFFFFFFF, 0, 1, 2, 3, 4, 0, 1);
    r.fixed = 1; r.want.err = comam_pkg::ERR_ZERO_MASS; rows.push_back(r);

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i]) begin
      send_word(rows[i].p);
      if (rows[i].fixed && rows[i].p.lst) begin
        void'(pending_sums.pop_back());
        pending_sums.push_back(rows[i].want);
      end
    end

    // Overflow: MAX_PARTICLES + 2 words in one set, zero mass on all but the first four
    for (int i = 0; i < NPART + 2; i++) begin
      particle_t p;
      p = rand_particle(i == NPART + 1);
      if (i > 3) p.m = 0;
      send_word(p);
    end
    // Exactly full set, not overflowed
    for (int i = 0; i < NPART; i++) send_word(rand_particle(i == NPART - 1));

    // Random sets, mostly small, up to about 950 words in all
    sent = rows.size() + 2 * NPART + 2;
    while (sent < 950) begin
      sz = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 6);
      if (sent > 850) begin in_calm = 1; out_calm = 1; end
      for (int i = 0; i < sz; i++) send_word(rand_particle(i == sz - 1));
      sent += sz;
    end
    in_valid <= 1'b0;

    while (pending_sums.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (errors == 0 && pending_sums.size() == 0) $display("tb: done, clean");
    else $display("tb: done, errors");
    $finish;
  end
endmodule
`default_nettype wire

[files.f]
src/comam_pkg.sv
src/comam_ram.sv
src/comam_div.sv
src/comam_datapath.sv
src/comam_ctrl.sv
src/center_of_mass_angular_momentum.sv
sim/tb.sv
